// ===== hw/rtl/region_overlap_best_match_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the region overlap best match unit
// Shorthand for clocked assertions that share clock and reset.
// ----------------------------------------------------------------------------
`ifndef REGION_OVERLAP_BEST_MATCH_UNIT_ASSERT_SVH
`define REGION_OVERLAP_BEST_MATCH_UNIT_ASSERT_SVH

// Implication within the same cycle
`define ROBM_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// Implication in the next cycle
`define ROBM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/robm_pkg.sv =====
// ----------------------------------------------------------------------------
// robm_pkg
// Shared types, sizes and helpers of the region overlap best match unit.
// ----------------------------------------------------------------------------
package robm_pkg;

   localparam int MAX_CANDIDATES = 64;
   localparam int COORD_BITS     = 13;
   localparam int SLOT_BITS      = 6;
   localparam int AREA_BITS      = 2 * COORD_BITS;
   localparam int IDX_BITS       = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;

   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   typedef logic [COORD_BITS-1:0] coord_type;
   typedef logic [AREA_BITS-1:0]  area_type;
   typedef logic [IDX_BITS-1:0]   idx_type;

   typedef struct packed {
      coord_type l;
      coord_type t;
      coord_type r;
      coord_type b;
      logic      sub;
   } cand_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_QAREA,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } robm_state_type;

   // Span of [lo, hi), zero when empty or inverted
   function automatic coord_type span0(input coord_type lo, input coord_type hi);
      coord_type res;
      res = (hi > lo) ? coord_type'(hi - lo) : '0;
      return res;
   endfunction

endpackage

// ===== hw/rtl/robm_req_if.sv =====
// ----------------------------------------------------------------------------
// robm_req_if
// Request channel: candidate writes and query rectangles.
// ----------------------------------------------------------------------------
interface robm_req_if;
   import robm_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  func;
   logic [SLOT_BITS-1:0]  slot;
   coord_type             left;
   coord_type             top;
   coord_type             right;
   coord_type             bottom;
   logic                  is_subslot;
   logic                  entry_valid;

   modport source (output valid, func, slot, left, top, right, bottom, is_subslot,
                   entry_valid, input ready);
   modport sink   (input valid, func, slot, left, top, right, bottom, is_subslot,
                   entry_valid, output ready);
endinterface

// ----------------------------------------------------------------------------
// robm_rsp_if
// Response channel: one match result per query.
// ----------------------------------------------------------------------------
interface robm_rsp_if;
   import robm_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  found;
   logic [SLOT_BITS-1:0]  best_slot;
   logic                  best_tier;
   area_type              overlap_area;
   area_type              query_area;

   modport source (output valid, found, best_slot, best_tier, overlap_area, query_area,
                   input ready);
   modport sink   (input valid, found, best_slot, best_tier, overlap_area, query_area,
                   output ready);
endinterface

// ===== hw/rtl/region_overlap_best_match_unit.sv =====
// ----------------------------------------------------------------------------
// region_overlap_best_match_unit
// Candidate rectangle table with a sequential best-overlap search.
// ----------------------------------------------------------------------------
// A candidate write (func 0) gives no response. A query (func 1) goes through
// the query area multiply, one table read per entry through the single read
// port of the candidate memory, a three-stage overlap pipeline to drain, a
// state that sees the pipeline empty, and a state that loads the response
// register once any earlier response has been taken. The request side is
// ready again once the response is loaded, so a write or the next query may
// be taken while the response still waits.
`include "region_overlap_best_match_unit_assert.svh"

module region_overlap_best_match_unit (
   input  logic        clock,
   input  logic        reset,
   robm_req_if.sink    req_ch,
   robm_rsp_if.source  rsp_ch
);
   import robm_pkg::*;

   localparam idx_type LAST_IDX = idx_type'(MAX_CANDIDATES - 1);

   // Sequencer
   robm_state_type state_ff, state_in;
   logic           req_ready;
   logic           issue;
   logic           load_rsp;

   // Candidate table: coordinates in memory, valid bits in flops
   cand_type                    cand_mem [MAX_CANDIDATES];
   logic [MAX_CANDIDATES-1:0]   valid_ff, valid_in;

   // Query held for the search
   coord_type q_l_ff, q_t_ff, q_r_ff, q_b_ff;
   coord_type q_w_ff, q_h_ff;
   area_type  qarea_ff;

   idx_type   scan_cnt_ff, scan_cnt_in;

   // Stage A: table read
   cand_type  rd_data_ff;
   logic      rd_busy_ff, rd_live_ff;
   idx_type   rd_idx_ff;

   // Stage B: intersection and candidate spans
   logic      b_busy_ff, b_live_ff, b_sub_ff;
   idx_type   b_idx_ff;
   coord_type b_iw_ff, b_ih_ff, b_cw_ff, b_ch_ff;

   // Stage C: areas
   logic      c_busy_ff, c_live_ff, c_sub_ff;
   idx_type   c_idx_ff;
   area_type  c_inter_ff, c_area_ff;

   // Per-tier best so far, index 1 = sub-slot, 0 = element
   logic      best_found_ff [2];
   idx_type   best_idx_ff   [2];
   area_type  best_inter_ff [2];
   area_type  best_area_ff  [2];

   // Response register
   logic                 rsp_valid_ff;
   logic                 rsp_found_ff;
   logic [SLOT_BITS-1:0] rsp_slot_ff;
   logic                 rsp_tier_ff;
   area_type             rsp_overlap_ff;
   area_type             rsp_qarea_ff;

   logic req_acc, wr_acc, query_acc;

   assign req_acc   = req_ch.valid && req_ready;
   assign wr_acc    = req_acc && (req_ch.func == FUNC_WRITE);
   assign query_acc = req_acc && (req_ch.func == FUNC_QUERY);

   // ------------------------------------------------------------------------
   // Sequencer: next state
   // ------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (query_acc) state_in = ST_QAREA;
         end
         ST_QAREA: begin
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (scan_cnt_ff == LAST_IDX) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (!rd_busy_ff && !b_busy_ff && !c_busy_ff) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ch.ready) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Sequencer: outputs
   always_comb begin
      req_ready = 1'b0;
      issue     = 1'b0;
      load_rsp  = 1'b0;
      case (state_ff)
         ST_IDLE:   req_ready = 1'b1;
         ST_SCAN:   issue     = 1'b1;
         ST_FINISH: load_rsp  = !rsp_valid_ff || rsp_ch.ready;
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   assign req_ch.ready = req_ready;

   // ------------------------------------------------------------------------
   // Candidate table writes; drop writes to slots beyond the table
   // ------------------------------------------------------------------------
   logic    wr_in_range;
   idx_type wr_idx;

   assign wr_in_range = 32'(req_ch.slot) < MAX_CANDIDATES;
   assign wr_idx      = idx_type'(req_ch.slot);

   always_comb begin
      valid_in = valid_ff;
      if (wr_acc && wr_in_range) valid_in[wr_idx] = req_ch.entry_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= '0;
      else       valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (wr_acc && wr_in_range) begin
         cand_mem[wr_idx] <= '{l: req_ch.left, t: req_ch.top, r: req_ch.right,
                               b: req_ch.bottom, sub: req_ch.is_subslot};
      end
   end

   // ------------------------------------------------------------------------
   // Query capture and area: floor each side at 1, multiply in the next cycle
   // ------------------------------------------------------------------------
   coord_type qw_raw, qh_raw;

   assign qw_raw = span0(req_ch.left, req_ch.right);
   assign qh_raw = span0(req_ch.top, req_ch.bottom);

   always_ff @(posedge clock) begin
      if (query_acc) begin
         q_l_ff <= req_ch.left;
         q_t_ff <= req_ch.top;
         q_r_ff <= req_ch.right;
         q_b_ff <= req_ch.bottom;
         q_w_ff <= (qw_raw == '0) ? coord_type'(1) : qw_raw;
         q_h_ff <= (qh_raw == '0) ? coord_type'(1) : qh_raw;
      end
      if (state_ff == ST_QAREA) qarea_ff <= area_type'(q_w_ff) * area_type'(q_h_ff);
   end

   // ------------------------------------------------------------------------
   // Scan counter: one table entry per cycle
   // ------------------------------------------------------------------------
   always_comb begin
      scan_cnt_in = scan_cnt_ff;
      if (query_acc)  scan_cnt_in = '0;
      else if (issue) scan_cnt_in = scan_cnt_ff + idx_type'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) scan_cnt_ff <= '0;
      else       scan_cnt_ff <= scan_cnt_in;
   end

   // Stage A: registered read; carry the entry's valid bit alongside
   always_ff @(posedge clock) begin
      rd_data_ff <= cand_mem[scan_cnt_ff];
      rd_idx_ff  <= scan_cnt_ff;
      rd_live_ff <= valid_ff[scan_cnt_ff];
   end

   // Stage B: clip the candidate to the query
   coord_type il, it, ir, ib;
   logic      nonempty;

   always_comb begin
      il = (q_l_ff > rd_data_ff.l) ? q_l_ff : rd_data_ff.l;
      it = (q_t_ff > rd_data_ff.t) ? q_t_ff : rd_data_ff.t;
      ir = (q_r_ff < rd_data_ff.r) ? q_r_ff : rd_data_ff.r;
      ib = (q_b_ff < rd_data_ff.b) ? q_b_ff : rd_data_ff.b;
      nonempty = (ir > il) && (ib > it);
   end

   always_ff @(posedge clock) begin
      b_live_ff <= rd_live_ff && nonempty;
      b_sub_ff  <= rd_data_ff.sub;
      b_idx_ff  <= rd_idx_ff;
      b_iw_ff   <= coord_type'(ir - il);
      b_ih_ff   <= coord_type'(ib - it);
      b_cw_ff   <= span0(rd_data_ff.l, rd_data_ff.r);
      b_ch_ff   <= span0(rd_data_ff.t, rd_data_ff.b);
   end

   // Stage C: intersection and candidate areas
   always_ff @(posedge clock) begin
      c_live_ff  <= b_live_ff;
      c_sub_ff   <= b_sub_ff;
      c_idx_ff   <= b_idx_ff;
      c_inter_ff <= area_type'(b_iw_ff) * area_type'(b_ih_ff);
      c_area_ff  <= area_type'(b_cw_ff) * area_type'(b_ch_ff);
   end

   // Pipeline occupancy, kept apart from entry validity so drain is exact
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_busy_ff <= 1'b0;
         b_busy_ff  <= 1'b0;
         c_busy_ff  <= 1'b0;
      end else begin
         rd_busy_ff <= issue;
         b_busy_ff  <= rd_busy_ff;
         c_busy_ff  <= b_busy_ff;
      end
   end

   // Stage D: half-overlap check and compare with the best of the same tier.
   // Strict compares keep the lowest slot on a full tie.
   logic qualifies, better, take;

   always_comb begin
      qualifies = {c_inter_ff, 1'b0} >= {1'b0, qarea_ff};
      better    = !best_found_ff[c_sub_ff]
               || (c_inter_ff > best_inter_ff[c_sub_ff])
               || ((c_inter_ff == best_inter_ff[c_sub_ff])
                   && (c_area_ff < best_area_ff[c_sub_ff]));
      take      = c_busy_ff && c_live_ff && qualifies && better;
   end

   always_ff @(posedge clock) begin
      if (reset || query_acc) begin
         best_found_ff[0] <= 1'b0;
         best_found_ff[1] <= 1'b0;
      end else if (take) begin
         best_found_ff[c_sub_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         best_idx_ff[c_sub_ff]   <= c_idx_ff;
         best_inter_ff[c_sub_ff] <= c_inter_ff;
         best_area_ff[c_sub_ff]  <= c_area_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Response register: sub-slot tier first, elements only as fallback
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_qarea_ff <= qarea_ff;
         if (best_found_ff[1]) begin
            rsp_found_ff   <= 1'b1;
            rsp_slot_ff    <= SLOT_BITS'(best_idx_ff[1]);
            rsp_tier_ff    <= 1'b1;
            rsp_overlap_ff <= best_inter_ff[1];
         end else if (best_found_ff[0]) begin
            rsp_found_ff   <= 1'b1;
            rsp_slot_ff    <= SLOT_BITS'(best_idx_ff[0]);
            rsp_tier_ff    <= 1'b0;
            rsp_overlap_ff <= best_inter_ff[0];
         end else begin
            rsp_found_ff   <= 1'b0;
            rsp_slot_ff    <= '0;
            rsp_tier_ff    <= 1'b0;
            rsp_overlap_ff <= '0;
         end
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.found        = rsp_found_ff;
   assign rsp_ch.best_slot    = rsp_slot_ff;
   assign rsp_ch.best_tier    = rsp_tier_ff;
   assign rsp_ch.overlap_area = rsp_overlap_ff;
   assign rsp_ch.query_area   = rsp_qarea_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   `ROBM_ASSERT_NEXT(a_query_starts_search, query_acc, state_ff == ST_QAREA,
                     "query did not start a search")
   `ROBM_ASSERT_SAME(a_finish_drained, state_ff == ST_FINISH,
                     !rd_busy_ff && !b_busy_ff && !c_busy_ff,
                     "result formed with pipeline busy")
   `ROBM_ASSERT_SAME(a_winner_half_overlap, rsp_valid_ff && rsp_found_ff,
                     {rsp_overlap_ff, 1'b0} >= {1'b0, rsp_qarea_ff},
                     "winner below half overlap")
   `ROBM_ASSERT_SAME(a_no_winner_zero, rsp_valid_ff && !rsp_found_ff,
                     (rsp_slot_ff == '0) && !rsp_tier_ff && (rsp_overlap_ff == '0),
                     "empty result not cleared")

endmodule

// ===== sim/robm_match_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// robm_match_checker
// Watches the request and response channels of the region overlap best match
// unit, keeps its own copy of the candidate table, predicts the match for
// every accepted query and compares each accepted response with the oldest
// prediction still waiting.
// ----------------------------------------------------------------------------
module robm_match_checker (
   input  logic clock,
   input  logic reset,
   robm_req_if  req_mon,
   robm_rsp_if  rsp_mon,
   output int   mismatch_count,
   output int   pending_count
);
   import robm_pkg::*;

   typedef struct packed {
      logic                 found;
      logic [SLOT_BITS-1:0] slot;
      logic                 tier;
      area_type             overlap;
      area_type             qarea;
   } match_type;

   cand_type  cands   [MAX_CANDIDATES];
   logic      cand_on [MAX_CANDIDATES];
   match_type expected_matches [$];
   int        errors = 0;

   // Sub-slots first; elements only when no sub-slot clears half the query.
   function automatic match_type predict_best_match(input coord_type ql, input coord_type qt,
                                                    input coord_type qr, input coord_type qb);
      match_type   res;
      logic [31:0] qw, qh, qarea, inter, carea, best_inter, best_area;
      coord_type   il, it, ir, ib;
      int          best, i, pass;
      logic        want_sub;
      res        = '0;
      qw         = (qr > ql) ? 32'(qr - ql) : 32'd1;
      qh         = (qb > qt) ? 32'(qb - qt) : 32'd1;
      qarea      = qw * qh;
      best       = -1;
      best_inter = '0;
      best_area  = '0;
      want_sub   = 1'b1;
      for (pass = 0; pass < 2; pass++) begin
         if (best < 0) begin
            want_sub = (pass == 0);
            for (i = 0; i < MAX_CANDIDATES; i++) begin
               il = (ql > cands[i].l) ? ql : cands[i].l;
               it = (qt > cands[i].t) ? qt : cands[i].t;
               ir = (qr < cands[i].r) ? qr : cands[i].r;
               ib = (qb < cands[i].b) ? qb : cands[i].b;
               if (cand_on[i] && cands[i].sub == want_sub && ir > il && ib > it) begin
                  inter = 32'(ir - il) * 32'(ib - it);
                  carea = ((cands[i].r > cands[i].l) ? 32'(cands[i].r - cands[i].l) : 32'd0) *
                          ((cands[i].b > cands[i].t) ? 32'(cands[i].b - cands[i].t) : 32'd0);
                  if (2 * inter >= qarea &&
                      (best < 0 || inter > best_inter ||
                       (inter == best_inter && carea < best_area))) begin
                     best       = i;
                     best_inter = inter;
                     best_area  = carea;
                  end
               end
            end
         end
      end
      if (best >= 0) begin
         res.found   = 1'b1;
         res.slot    = SLOT_BITS'(best);
         res.tier    = want_sub;
         res.overlap = area_type'(best_inter);
      end
      res.qarea = area_type'(qarea);
      return res;
   endfunction

   always @(posedge clock) begin
      match_type got, want;
      int        i;
      if (reset) begin
         for (i = 0; i < MAX_CANDIDATES; i++) begin
            cands[i]   = '0;
            cand_on[i] = 1'b0;
         end
         expected_matches.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.found   = rsp_mon.found;
            got.slot    = rsp_mon.best_slot;
            got.tier    = rsp_mon.best_tier;
            got.overlap = rsp_mon.overlap_area;
            got.qarea   = rsp_mon.query_area;
            if (expected_matches.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("%0t: response with no query outstanding", $realtime);
            end else begin
               want = expected_matches.pop_front();
               if (got.found !== want.found || got.slot !== want.slot ||
                   got.tier !== want.tier || got.overlap !== want.overlap ||
                   got.qarea !== want.qarea) begin
                  errors++;
                  if (errors <= 10) begin
                     $display("%0t: match mismatch: expected found=%0d slot=%0d tier=%0d",
                              $realtime, want.found, want.slot, want.tier);
                     $display("   expected overlap=%0d qarea=%0d", want.overlap, want.qarea);
                     $display("   got found=%0d slot=%0d tier=%0d overlap=%0d qarea=%0d",
                              got.found, got.slot, got.tier, got.overlap, got.qarea);
                  end
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.func == FUNC_WRITE) begin
               if (req_mon.slot < MAX_CANDIDATES) begin
                  cands[req_mon.slot]   = '{l: req_mon.left, t: req_mon.top, r: req_mon.right,
                                            b: req_mon.bottom, sub: req_mon.is_subslot};
                  cand_on[req_mon.slot] = req_mon.entry_valid;
               end
            end else begin
               expected_matches.push_back(predict_best_match(req_mon.left, req_mon.top,
                                                             req_mon.right, req_mon.bottom));
            end
         end
      end
      mismatch_count <= errors;
      pending_count  <= expected_matches.size();
   end

endmodule

// ===== sim/tb_region_overlap_best_match_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_region_overlap_best_match_unit
// Drives candidate writes and region queries into the best match unit with
// bursty requests and a stalling receiver; the match checker beside the block
// predicts every response and counts mismatches for the verdict.
// ----------------------------------------------------------------------------
module tb_region_overlap_best_match_unit;
   import robm_pkg::*;

   localparam int RANDOM_REQUESTS = 1350;
   localparam int STALL_LIMIT     = 4000;              // cycles with no handshake at all
   localparam int LONG_HOLD       = 600;               // receiver back-pressure stretch
   localparam int SETTLE_CYCLES   = MAX_CANDIDATES + 16;

   logic clock;
   logic reset;
   int   mismatches;
   int   outstanding;
   int   idle_cycles = 0;
   int   burst_left  = 0;
   bit   long_hold_req = 1'b0;

   robm_req_if req_ch ();
   robm_rsp_if rsp_ch ();

   region_overlap_best_match_unit u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   robm_match_checker u_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_ch),
      .rsp_mon        (rsp_ch),
      .mismatch_count (mismatches),
      .pending_count  (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Offer one request and hold it until the block takes it, then decide
   // whether the current burst goes on or a gap follows.
   task automatic issue(input logic func, input logic [SLOT_BITS-1:0] slot,
                        input int l, input int t, input int r, input int b,
                        input logic sub, input logic active);
      int gap;
      req_ch.valid       <= 1'b1;
      req_ch.func        <= func;
      req_ch.slot        <= slot;
      req_ch.left        <= coord_type'(l);
      req_ch.top         <= coord_type'(t);
      req_ch.right       <= coord_type'(r);
      req_ch.bottom      <= coord_type'(b);
      req_ch.is_subslot  <= sub;
      req_ch.entry_valid <= active;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         // Mostly short bursts, now and then a long run with no gaps at all
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                  : $urandom_range(0, 12);
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 6);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Drop the request and wait for every predicted response to come back.
   // The extra edge lets the outstanding count catch up with the last request.
   task automatic await_idle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // Request stimulus and verdict
   initial begin
      int n, pick, cx, cy, l, t, r, b;
      int last_l, last_t, last_r, last_b;
      logic [SLOT_BITS-1:0] slot;
      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.func        <= FUNC_WRITE;
      req_ch.slot        <= '0;
      req_ch.left        <= '0;
      req_ch.top         <= '0;
      req_ch.right       <= '0;
      req_ch.bottom      <= '0;
      req_ch.is_subslot  <= 1'b0;
      req_ch.entry_valid <= 1'b0;
      cx = 0;
      cy = 0;
      last_l = 100;
      last_t = 100;
      last_r = 120;
      last_b = 120;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Empty table: nothing found, full-range query gives the largest area
      issue(FUNC_QUERY, 6'd0, 0, 0, 8191, 8191, 1'b0, 1'b0);
      // Inverted query: both sides floor at one pixel
      issue(FUNC_QUERY, 6'd63, 5000, 300, 4000, 200, 1'b1, 1'b1);
      // Full-frame element in the first slot, sub-slot in the last
      issue(FUNC_WRITE, 6'd0, 0, 0, 8191, 8191, 1'b0, 1'b1);
      issue(FUNC_WRITE, 6'd63, 100, 100, 200, 200, 1'b1, 1'b1);
      // Sub-slot tier wins over the element
      issue(FUNC_QUERY, 6'd0, 100, 100, 200, 200, 1'b0, 1'b0);
      // Sub-slot too small for the query: fall back to the element tier
      issue(FUNC_QUERY, 6'd0, 0, 0, 8191, 8191, 1'b0, 1'b0);
      // Duplicate in a lower slot, and a larger sub-slot with equal overlap
      issue(FUNC_WRITE, 6'd5, 100, 100, 200, 200, 1'b1, 1'b1);
      issue(FUNC_WRITE, 6'd6, 90, 90, 210, 210, 1'b1, 1'b1);
      issue(FUNC_QUERY, 6'd0, 100, 100, 200, 200, 1'b0, 1'b0);
      // Slots 5 and 63 overlap exactly half the query, then just under half
      issue(FUNC_QUERY, 6'd0, 100, 100, 300, 200, 1'b0, 1'b0);
      issue(FUNC_QUERY, 6'd0, 100, 100, 301, 200, 1'b0, 1'b0);
      // Remove entries and check that the larger one now wins
      issue(FUNC_WRITE, 6'd63, 100, 100, 200, 200, 1'b1, 1'b0);
      issue(FUNC_WRITE, 6'd5, 100, 100, 200, 200, 1'b1, 1'b0);
      issue(FUNC_QUERY, 6'd0, 100, 100, 200, 200, 1'b0, 1'b0);
      // Edge-adjacent rectangles share no pixel
      issue(FUNC_WRITE, 6'd7, 200, 100, 300, 200, 1'b1, 1'b1);
      issue(FUNC_QUERY, 6'd0, 300, 100, 400, 200, 1'b0, 1'b0);
      // Empty and inverted candidates never qualify
      issue(FUNC_WRITE, 6'd8, 8191, 8191, 8191, 8191, 1'b1, 1'b1);
      issue(FUNC_WRITE, 6'd9, 4000, 4000, 3000, 3000, 1'b1, 1'b1);
      issue(FUNC_QUERY, 6'd0, 3500, 3500, 3600, 3600, 1'b0, 1'b0);
      issue(FUNC_QUERY, 6'd0, 8190, 8190, 8191, 8191, 1'b0, 1'b0);
      // No valid element left that covers the corner pixel
      issue(FUNC_WRITE, 6'd0, 0, 0, 8191, 8191, 1'b0, 1'b0);
      issue(FUNC_QUERY, 6'd0, 8190, 8190, 8191, 8191, 1'b0, 1'b0);
      await_idle();

      // Random part: candidates and queries share a small cluster so that
      // most queries meet candidates, with full-range noise mixed in.
      for (n = 0; n < RANDOM_REQUESTS; n++) begin
         if (n % 250 == 0) begin
            cx = $urandom_range(0, 8191 - 96);
            cy = $urandom_range(0, 8191 - 96);
         end
         if (n == 350 || n == 1000)
            await_idle();
         if (n == 650)
            long_hold_req = 1'b1;
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            issue(1'($urandom_range(0, 1)), 6'($urandom_range(0, 63)),
                  $urandom_range(0, 8191), $urandom_range(0, 8191),
                  $urandom_range(0, 8191), $urandom_range(0, 8191),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         end else if (pick < 55) begin
            slot = 6'($urandom_range(0, 63));
            if ($urandom_range(0, 6) != 0) begin
               if ($urandom_range(0, 14) == 0) begin
                  // Empty or inverted candidate
                  last_r = cx + $urandom_range(0, 47);
                  last_l = last_r + $urandom_range(0, 3);
                  last_b = cy + $urandom_range(0, 47);
                  last_t = last_b + $urandom_range(0, 3);
               end else begin
                  last_l = cx + $urandom_range(0, 47);
                  last_r = last_l + $urandom_range(1, 32);
                  last_t = cy + $urandom_range(0, 47);
                  last_b = last_t + $urandom_range(1, 32);
               end
            end
            // Otherwise repeat the previous rectangle to force ties
            issue(FUNC_WRITE, slot, last_l, last_t, last_r, last_b,
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 9) != 0));
         end else begin
            if ($urandom_range(0, 2) == 0) begin
               // Near the last written candidate
               l = last_l;
               r = last_r + $urandom_range(0, 8);
               t = last_t + $urandom_range(0, 4);
               b = last_b;
            end else begin
               l = cx + $urandom_range(0, 60);
               r = l + $urandom_range(0, 20);
               t = cy + $urandom_range(0, 60);
               b = t + $urandom_range(0, 20);
            end
            issue(FUNC_QUERY, 6'($urandom_range(0, 63)), l, t, r, b,
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         end
      end

      await_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("region_overlap_best_match_unit test passed");
      end else begin
         $display("region_overlap_best_match_unit test failed");
      end
      $finish;
   end

   // Response receiver: stall on its own pattern, switching mode now and then;
   // once asked, hold off for a long stretch so the block backs up.
   initial begin
      int mode, span, phase;
      rsp_ch.ready <= 1'b0;
      phase = 0;
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(20, 200);
         repeat (span) begin
            @(posedge clock);
            if (long_hold_req) begin
               long_hold_req = 1'b0;
               rsp_ch.ready <= 1'b0;
               repeat (LONG_HOLD) @(posedge clock);
            end
            phase++;
            case (mode)
               0: begin
                  rsp_ch.ready <= 1'b1;
               end
               1: begin
                  rsp_ch.ready <= ($urandom_range(0, 3) != 0);
               end
               2: begin
                  rsp_ch.ready <= ($urandom_range(0, 3) == 0);
               end
               default: begin
                  rsp_ch.ready <= ((phase % 7) < 3);
               end
            endcase
         end
      end
   end

   // Watchdog: give up when neither channel has moved for too long
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == STALL_LIMIT) begin
         $display("region_overlap_best_match_unit test failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/robm_pkg.sv
hw/rtl/robm_req_if.sv
hw/rtl/region_overlap_best_match_unit.sv
sim/robm_match_checker.sv
sim/tb_region_overlap_best_match_unit.sv
